@@ rtl/epc_pkg.sv @@
// Package for the epoch-to-calendar-date converter.
// Holds the constants, tables and beat structs shared by the datapath modules.
// No dependencies.
package epc_pkg;

   localparam int TS_W   = 32;
   localparam int DAYS_W = 16;
   localparam int YEAR_W = 12;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);
   localparam logic [6:0] EPOCH_MOD100 = 7'(1970 % 100);
   localparam logic [8:0] EPOCH_MOD400 = 9'(1970 % 400);

   localparam logic [17:0] SECS_PER_HOUR = 18'd3600;

   localparam logic [8:0] DAYS_COMMON = 9'd365;
   localparam logic [8:0] DAYS_LEAP   = 9'd366;

   // Register index taken from paddr[2].
   localparam logic REG_UTC_OFFSET = 1'b0;

   // Division passes of the time split.
   localparam logic [1:0] PASS_SEC  = 2'd0;
   localparam logic [1:0] PASS_MIN  = 2'd1;
   localparam logic [1:0] PASS_HOUR = 2'd2;

   // Quotient bits left after each pass.
   localparam int SEC_QBITS = 27;
   localparam int MIN_QBITS = 21;
   localparam int SEC_SHIFT = TS_W - SEC_QBITS;
   localparam int MIN_SHIFT = TS_W - MIN_QBITS;

   localparam logic [3:0] MONTH_JAN = 4'd0;
   localparam logic [3:0] MONTH_FEB = 4'd1;
   localparam logic [3:0] MONTH_DEC = 4'd11;

   typedef struct packed {
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic [DAYS_W-1:0] days;
   } tsplit_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [3:0]        month;
      logic [4:0]        day;
   } date_type;

   function automatic logic [5:0] split_divisor(input logic [1:0] pass);
      logic [5:0] d;
      case (pass)
         PASS_SEC: d = 6'd60;
         PASS_MIN: d = 6'd60;
         default:  d = 6'd24;
      endcase
      return d;
   endfunction

   function automatic logic [4:0] split_len_m1(input logic [1:0] pass);
      logic [4:0] n;
      case (pass)
         PASS_SEC: n = 5'(TS_W - 1);
         PASS_MIN: n = 5'(SEC_QBITS - 1);
         default:  n = 5'(MIN_QBITS - 1);
      endcase
      return n;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] mo);
      logic [4:0] n;
      case (mo)
         4'd0:    n = 5'd31;
         4'd1:    n = 5'd28;
         4'd2:    n = 5'd31;
         4'd3:    n = 5'd30;
         4'd4:    n = 5'd31;
         4'd5:    n = 5'd30;
         4'd6:    n = 5'd31;
         4'd7:    n = 5'd31;
         4'd8:    n = 5'd30;
         4'd9:    n = 5'd31;
         4'd10:   n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

@@ rtl/epc_tsplit.sv @@
// Bit-serial split of a second count into second, minute, hour and days.
// One restoring-division bit per cycle by 60, 60 and 24 in turn.
// Depends on epc_pkg.
module epc_tsplit (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [31:0]        dividend,
   output logic               done,
   output epc_pkg::tsplit_type result
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [1:0]  pass_ff, pass_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] sh_ff, sh_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;

   logic [6:0]  trial;
   logic [5:0]  divisor;
   logic        ge;
   logic [5:0]  nrem;
   logic [31:0] shifted;

   always_comb begin
      divisor = epc_pkg::split_divisor(pass_ff);
      trial   = {rem_ff, sh_ff[31]};
      ge      = trial >= {1'b0, divisor};
      nrem    = ge ? 6'(trial - {1'b0, divisor}) : trial[5:0];
      shifted = {sh_ff[30:0], ge};

      run_in  = run_ff;
      done_in = 1'b0;
      pass_in = pass_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;

      if (load) begin
         sh_in   = dividend;
         rem_in  = 6'd0;
         pass_in = epc_pkg::PASS_SEC;
         cnt_in  = epc_pkg::split_len_m1(epc_pkg::PASS_SEC);
         run_in  = 1'b1;
      end else if (run_ff) begin
         sh_in  = shifted;
         rem_in = nrem;
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            rem_in = 6'd0;
            case (pass_ff)
               epc_pkg::PASS_SEC: begin
                  sec_in  = nrem;
                  sh_in   = shifted << epc_pkg::SEC_SHIFT;
                  pass_in = epc_pkg::PASS_MIN;
                  cnt_in  = epc_pkg::split_len_m1(epc_pkg::PASS_MIN);
               end
               epc_pkg::PASS_MIN: begin
                  min_in  = nrem;
                  sh_in   = shifted << epc_pkg::MIN_SHIFT;
                  pass_in = epc_pkg::PASS_HOUR;
                  cnt_in  = epc_pkg::split_len_m1(epc_pkg::PASS_HOUR);
               end
               default: begin
                  hour_in = nrem[4:0];
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= epc_pkg::PASS_SEC;
         cnt_ff  <= 5'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      sec_ff  <= sec_in;
      min_ff  <= min_in;
      hour_ff <= hour_in;
   end

   assign done          = done_ff;
   assign result.hour   = hour_ff;
   assign result.minute = min_ff;
   assign result.second = sec_ff;
   assign result.days   = sh_ff[epc_pkg::DAYS_W-1:0];

endmodule

@@ rtl/epc_calwalk.sv @@
// Year and month walk: takes whole days since the epoch apart, one year or
// one month per cycle, with Gregorian leap rules. Depends on epc_pkg.
module epc_calwalk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [epc_pkg::DAYS_W-1:0]     days,
   output logic                           done,
   output epc_pkg::date_type              date
);

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_YEAR,
      WALK_MONTH
   } walk_state_type;

   walk_state_type                  state_ff, state_in;
   logic                            done_ff, done_in;
   logic [epc_pkg::DAYS_W-1:0]      days_ff, days_in;
   logic [epc_pkg::YEAR_W-1:0]      year_ff, year_in;
   logic [6:0]                      c100_ff, c100_in;
   logic [8:0]                      c400_ff, c400_in;
   logic [3:0]                      mo_ff, mo_in;

   logic                            leap;
   logic [8:0]                      year_len;
   logic [4:0]                      mon_len;

   always_comb begin
      leap     = (year_ff[1:0] == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
      year_len = leap ? epc_pkg::DAYS_LEAP : epc_pkg::DAYS_COMMON;
      mon_len  = (mo_ff == epc_pkg::MONTH_FEB && leap) ? 5'd29 : epc_pkg::month_len(mo_ff);

      state_in = state_ff;
      done_in  = 1'b0;
      days_in  = days_ff;
      year_in  = year_ff;
      c100_in  = c100_ff;
      c400_in  = c400_ff;
      mo_in    = mo_ff;

      if (load) begin
         days_in  = days;
         year_in  = epc_pkg::EPOCH_YEAR;
         c100_in  = epc_pkg::EPOCH_MOD100;
         c400_in  = epc_pkg::EPOCH_MOD400;
         mo_in    = epc_pkg::MONTH_JAN;
         state_in = WALK_YEAR;
      end else begin
         case (state_ff)
            WALK_YEAR: begin
               if (days_ff < epc_pkg::DAYS_W'(year_len)) begin
                  state_in = WALK_MONTH;
               end else begin
                  days_in = days_ff - epc_pkg::DAYS_W'(year_len);
                  year_in = year_ff + epc_pkg::YEAR_W'(1);
                  c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
                  c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
               end
            end
            WALK_MONTH: begin
               if (mo_ff == epc_pkg::MONTH_DEC || days_ff < epc_pkg::DAYS_W'(mon_len)) begin
                  state_in = WALK_IDLE;
                  done_in  = 1'b1;
               end else begin
                  days_in = days_ff - epc_pkg::DAYS_W'(mon_len);
                  mo_in   = mo_ff + 4'd1;
               end
            end
            default: begin
               state_in = WALK_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      days_ff <= days_in;
      year_ff <= year_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      mo_ff   <= mo_in;
   end

   assign done       = done_ff;
   assign date.year  = year_ff;
   assign date.month = mo_ff + 4'd1;
   assign date.day   = days_ff[4:0] + 5'd1;

endmodule

@@ rtl/epoch_to_calendar_date.sv @@
// Top level of the epoch-to-calendar-date converter: register port, offset add,
// sequencing and result beat. Depends on epc_pkg, epc_tsplit and epc_calwalk.
//
// A beat is taken when start is high and busy is low; one result beat follows,
// shown for exactly one cycle on rsp_strobe. A zero timestamp gives its result
// (rsp_date_valid low, all fields zero) in the next cycle with no busy time.
// Any other timestamp raises busy and goes through bit-serial division by 60,
// 60 and 24, then the calendar walk, which steps through each whole year past
// 1970 (at most 136) and then each month before that of the result (index 0
// to 11), then the hand-off to the result registers. One beat is in work at a
// time. utc_offset_hours is at byte address 0; the user must write it only
// while busy is low, and the block itself does not enforce this.
module epoch_to_calendar_date (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,

   output logic        rsp_strobe,
   output logic        rsp_date_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_WALK
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  offset_ff, offset_in;
   logic        strobe_ff, strobe_in;
   logic        valid_ff, valid_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic                 accept;
   logic                 cfg_write;
   logic signed [17:0]   off_secs;
   logic [31:0]          shifted_ts;
   logic                 split_load;
   logic                 split_done;
   epc_pkg::tsplit_type  split_res;
   logic                 walk_load;
   logic                 walk_done;
   epc_pkg::date_type    walk_date;

   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready
                      && (paddr[2] == epc_pkg::REG_UTC_OFFSET);
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == epc_pkg::REG_UTC_OFFSET) ? {27'd0, offset_ff} : 32'd0;

   assign off_secs   = $signed({{13{offset_ff[4]}}, offset_ff})
                       * $signed(epc_pkg::SECS_PER_HOUR);
   assign shifted_ts = req_epoch_seconds + {{14{off_secs[17]}}, off_secs};

   assign split_load = accept && (req_epoch_seconds != 32'd0);
   assign walk_load  = (state_ff == ST_SPLIT) && split_done;

   epc_tsplit u_tsplit (
      .clock    (clock),
      .reset    (reset),
      .load     (split_load),
      .dividend (shifted_ts),
      .done     (split_done),
      .result   (split_res)
   );

   epc_calwalk u_calwalk (
      .clock (clock),
      .reset (reset),
      .load  (walk_load),
      .days  (split_res.days),
      .done  (walk_done),
      .date  (walk_date)
   );

   always_comb begin
      state_in  = state_ff;
      offset_in = cfg_write ? pwdata[4:0] : offset_ff;
      strobe_in = 1'b0;
      valid_in  = valid_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_epoch_seconds == 32'd0) begin
                  strobe_in = 1'b1;
                  valid_in  = 1'b0;
                  year_in   = 12'd0;
                  month_in  = 4'd0;
                  day_in    = 5'd0;
                  hour_in   = 5'd0;
                  minute_in = 6'd0;
                  second_in = 6'd0;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (split_done) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               valid_in  = 1'b1;
               year_in   = walk_date.year;
               month_in  = walk_date.month;
               day_in    = walk_date.day;
               hour_in   = split_res.hour;
               minute_in = split_res.minute;
               second_in = split_res.second;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         offset_ff <= 5'd0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
         strobe_ff <= strobe_in;
      end
      valid_ff  <= valid_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_date_valid       = valid_ff;
   assign rsp_year             = year_ff;
   assign rsp_month            = month_ff;
   assign rsp_day_of_month     = day_ff;
   assign rsp_hour_of_day      = hour_ff;
   assign rsp_minute_of_hour   = minute_ff;
   assign rsp_second_of_minute = second_ff;

endmodule

@@ rtl/epc_checker.sv @@
// Port-level checks for epoch_to_calendar_date, bound to the top level.
// Depends only on the top level's ports.
module epc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [31:0] req_epoch_seconds,
   input logic        rsp_strobe,
   input logic        rsp_date_valid,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day_of_month,
   input logic [4:0]  rsp_hour_of_day,
   input logic [5:0]  rsp_minute_of_hour,
   input logic [5:0]  rsp_second_of_minute
);

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat shown while busy");

   a_zero_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_epoch_seconds == 32'd0)
      |=> (rsp_strobe && !rsp_date_valid && rsp_year == 12'd0 && rsp_month == 4'd0))
      else $error("zero timestamp did not give an invalid result next cycle");

   a_busy_on_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_epoch_seconds != 32'd0) |=> (busy && !rsp_strobe))
      else $error("nonzero timestamp did not start a conversion");

   a_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_date_valid)
      |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1
           && rsp_hour_of_day <= 5'd23 && rsp_minute_of_hour <= 6'd59
           && rsp_second_of_minute <= 6'd59 && rsp_year >= 12'd1970))
      else $error("result field out of range");

endmodule

bind epoch_to_calendar_date epc_checker u_epc_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_epoch_seconds    (req_epoch_seconds),
   .rsp_strobe           (rsp_strobe),
   .rsp_date_valid       (rsp_date_valid),
   .rsp_year             (rsp_year),
   .rsp_month            (rsp_month),
   .rsp_day_of_month     (rsp_day_of_month),
   .rsp_hour_of_day      (rsp_hour_of_day),
   .rsp_minute_of_hour   (rsp_minute_of_hour),
   .rsp_second_of_minute (rsp_second_of_minute)
);
